>>> rtl/phg_pkg.sv
// Shared types, constants and codes for the proximity hit grouper.
`default_nettype none
package phg_pkg;

    localparam int MAX_TOKENS = 64;
    localparam int MAX_TERMS  = 16;
    localparam int IDX_W      = $clog2(MAX_TOKENS);
    localparam int CNT_W      = IDX_W + 1;

    localparam logic [2:0] REG_UNIQUE_TERMS   = 3'd0;
    localparam logic [2:0] REG_WINDOW_SIZE    = 3'd1;
    localparam logic [2:0] REG_USE_SUBCONTEXT = 3'd2;
    localparam logic [2:0] REG_USE_SEQUENCES  = 3'd3;
    localparam logic [2:0] REG_COLLECT_ALL    = 3'd4;
    localparam logic [2:0] REG_DIRECTED       = 3'd5;

    typedef struct packed {
        logic [15:0] context_id;
        logic [15:0] subcontext_id;
        logic [15:0] position;
        logic [4:0]  term_number;
        logic [7:0]  seq_index;
        logic        seq_valid;
        logic        replaceable;
        logic        last_token;
    } in_item_t;

    typedef struct packed {
        logic [5:0] token_index;
        logic [7:0] hit_id;
        logic       last_result;
    } out_item_t;

    typedef struct packed {
        logic [15:0] context_id;
        logic [15:0] subcontext_id;
        logic [15:0] position;
        logic [4:0]  term_number;
        logic [7:0]  seq_index;
        logic        seq_valid;
        logic        replaceable;
    } token_t;

    typedef struct packed {
        logic [4:0]  unique_terms;
        logic [15:0] window_size;
        logic        use_subcontext;
        logic        use_sequences;
        logic        collect_all;
        logic        directed;
    } cfg_t;

    typedef struct packed {
        logic        brk;
        logic        take;
        logic        strict;
        logic [MAX_TERMS-1:0] term_bit;
    } match_t;

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_START, S_WREQ, S_WCHK, S_RREQ, S_RCHK,
        S_DONE, S_SWEEP, S_NEXT, S_OREQ, S_OLOAD, S_OHOLD
    } state_t;

endpackage
`default_nettype wire

>>> rtl/phg_match.sv
// Window, context and term tests of one walked token against the start token.
`default_nettype none
module phg_match (
    input  var phg_pkg::token_t tok,
    input  var phg_pkg::token_t start_tok,
    input  wire                 first,
    input  var phg_pkg::cfg_t   cfg,
    input  wire [phg_pkg::MAX_TERMS-1:0] terms_seen,
    input  wire [4:0]           term_count,
    input  wire                 assigned,
    output phg_pkg::match_t     res
);
    phg_pkg::token_t st;
    logic [16:0] diff;
    logic        far;
    logic        term_ok;
    logic [4:0]  tm1;
    logic [phg_pkg::MAX_TERMS-1:0] bit_m;
    logic        strict;
    logic        skip;

    always_comb
    begin
        st      = first ? tok : start_tok;
        diff    = {1'b0, tok.position} - {1'b0, st.position};
        far     = !diff[16] && (diff[15:0] > cfg.window_size);
        term_ok = (tok.term_number != 5'd0) &&
                  ({1'b0, tok.term_number} <= 6'(phg_pkg::MAX_TERMS));
        tm1     = tok.term_number - 5'd1;
        bit_m   = phg_pkg::MAX_TERMS'(1) << tm1[3:0];
        strict  = !tok.replaceable && !cfg.collect_all;
        skip    = strict && (assigned || ((terms_seen & bit_m) != '0));
        if (cfg.directed && ({1'b0, tok.term_number} > ({1'b0, term_count} + 6'd1)))
        begin
            skip = 1'b1;
        end
        res.brk      = (tok.context_id != st.context_id) || far ||
                       (cfg.use_subcontext && (tok.subcontext_id != st.subcontext_id));
        res.take     = term_ok && !skip;
        res.strict   = strict;
        res.term_bit = bit_m;
    end
endmodule
`default_nettype wire

>>> rtl/proximity_hit_grouper.sv
// Top level of the proximity hit grouper: token store, scan sequencer, result output.
//
// Usage: tokens arrive on the in channel (in_valid/in_ready, one token per beat) and
// are stored in load order, one per cycle; up to 64 are kept, later ones are dropped.
// A beat with last_token set closes the set, and in_ready falls while the set is
// scanned. Each start token walks from itself through the following tokens on the
// single read port of the store; with use_sequences on, a collected token with a
// valid sequence index also follows the run of tokens after it. A completed hit is
// followed by a sweep that writes its hit numbers, and a replaceable start may be
// walked again. Results then leave on the out channel, one beat per token in load
// order; last_result marks the final beat, after which in_ready rises again. A
// stalled out_ready holds the output register and the sequencer. Configuration
// writes (cfg_valid/cfg_index/cfg_data) are always taken and belong only to idle
// periods. Reset empties the token set, sets unique_terms to 1 and every other
// configuration register to 0; no clearing pass is needed.
`default_nettype none
module proximity_hit_grouper (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  var phg_pkg::in_item_t in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output phg_pkg::out_item_t  out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire [2:0]           cfg_index,
    input  wire [15:0]          cfg_data
);
    localparam int N = phg_pkg::MAX_TOKENS;
    localparam int IW = phg_pkg::IDX_W;
    localparam int CW = phg_pkg::CNT_W;

    phg_pkg::token_t tok_mem [N];
    logic [7:0]      hit_mem [N];

    phg_pkg::state_t state_reg, state_next;
    phg_pkg::cfg_t   cfg_reg;
    phg_pkg::token_t rd_reg, start_reg, start_next;
    logic [7:0]      hit_rd_reg;
    logic [CW-1:0]   cnt_reg, cnt_next, n_reg, n_next;
    logic [IW-1:0]   i_reg, i_next, w_reg, w_next, s_reg, s_next, k_reg, k_next;
    logic [IW-1:0]   rd_addr;
    logic [phg_pkg::MAX_TERMS-1:0] terms_reg, terms_next;
    logic [4:0]      tcount_reg, tcount_next, newc;
    logic [N-1:0]    mark_reg, mark_next, flag_reg, flag_next;
    logic [7:0]      next_hit_reg, next_hit_next;
    logic            first_reg, first_next, stop_reg, stop_next, fresh_reg, fresh_next;
    logic [15:0]     prev_pos_reg, prev_pos_next;
    logic [7:0]      prev_seq_reg, prev_seq_next;
    logic [4:0]      run_term_reg, run_term_next;
    logic            out_valid_reg, out_valid_next;
    phg_pkg::out_item_t out_reg, out_next;
    phg_pkg::match_t m;
    logic            in_acc, stop_now, run_ok, w_end, s_end;
    phg_pkg::token_t in_tok;

    assign in_ready  = (state_reg == phg_pkg::S_LOAD);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign in_acc    = in_valid && in_ready;
    assign in_tok    = in_data[$bits(phg_pkg::in_item_t)-1:1];

    phg_match u_match (
        .tok        (rd_reg),
        .start_tok  (start_reg),
        .first      (first_reg),
        .cfg        (cfg_reg),
        .terms_seen (terms_reg),
        .term_count (tcount_reg),
        .assigned   (flag_reg[w_reg]),
        .res        (m)
    );

    always_comb
    begin
        rd_addr = (state_reg == phg_pkg::S_RREQ) ? s_reg : w_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (cnt_reg < CW'(N)))
        begin
            tok_mem[cnt_reg[IW-1:0]] <= in_tok;
        end
        rd_reg <= tok_mem[rd_addr];
        if ((state_reg == phg_pkg::S_SWEEP) && mark_reg[k_reg])
        begin
            hit_mem[k_reg] <= next_hit_reg;
        end
        hit_rd_reg <= hit_mem[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unique_terms   <= 5'd1;
            cfg_reg.window_size    <= '0;
            cfg_reg.use_subcontext <= 1'b0;
            cfg_reg.use_sequences  <= 1'b0;
            cfg_reg.collect_all    <= 1'b0;
            cfg_reg.directed       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                phg_pkg::REG_UNIQUE_TERMS:   cfg_reg.unique_terms   <= cfg_data[4:0];
                phg_pkg::REG_WINDOW_SIZE:    cfg_reg.window_size    <= cfg_data;
                phg_pkg::REG_USE_SUBCONTEXT: cfg_reg.use_subcontext <= cfg_data[0];
                phg_pkg::REG_USE_SEQUENCES:  cfg_reg.use_sequences  <= cfg_data[0];
                phg_pkg::REG_COLLECT_ALL:    cfg_reg.collect_all    <= cfg_data[0];
                phg_pkg::REG_DIRECTED:       cfg_reg.directed       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= phg_pkg::S_LOAD;
            cnt_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            w_reg         <= '0;
            s_reg         <= '0;
            k_reg         <= '0;
            terms_reg     <= '0;
            tcount_reg    <= '0;
            mark_reg      <= '0;
            flag_reg      <= '0;
            next_hit_reg  <= 8'd1;
            first_reg     <= 1'b0;
            stop_reg      <= 1'b0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            w_reg         <= w_next;
            s_reg         <= s_next;
            k_reg         <= k_next;
            terms_reg     <= terms_next;
            tcount_reg    <= tcount_next;
            mark_reg      <= mark_next;
            flag_reg      <= flag_next;
            next_hit_reg  <= next_hit_next;
            first_reg     <= first_next;
            stop_reg      <= stop_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg    <= start_next;
        prev_pos_reg <= prev_pos_next;
        prev_seq_reg <= prev_seq_next;
        run_term_reg <= run_term_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        w_next         = w_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        terms_next     = terms_reg;
        tcount_next    = tcount_reg;
        mark_next      = mark_reg;
        flag_next      = flag_reg;
        next_hit_next  = next_hit_reg;
        first_next     = first_reg;
        stop_next      = stop_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg;
        start_next     = start_reg;
        prev_pos_next  = prev_pos_reg;
        prev_seq_next  = prev_seq_reg;
        run_term_next  = run_term_reg;
        out_next       = out_reg;
        w_end    = ({1'b0, w_reg} + CW'(1)) >= n_reg;
        s_end    = ({1'b0, s_reg} + CW'(1)) >= n_reg;
        newc     = tcount_reg + (((terms_reg & m.term_bit) != '0) ? 5'd0 : 5'd1);
        stop_now = m.strict && (newc == cfg_reg.unique_terms);
        run_ok   = ((rd_reg.position == prev_pos_reg) ||
                    ({1'b0, rd_reg.position} == ({1'b0, prev_pos_reg} + 17'd1))) &&
                   rd_reg.seq_valid &&
                   ({1'b0, rd_reg.seq_index} == ({1'b0, prev_seq_reg} + 9'd1));

        unique case (state_reg)
            phg_pkg::S_LOAD:
            begin
                if (in_acc)
                begin
                    if (cnt_reg < CW'(N))
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (in_data.last_token)
                    begin
                        n_next     = (cnt_reg < CW'(N)) ? cnt_reg + CW'(1) : cnt_reg;
                        state_next = phg_pkg::S_INIT;
                    end
                end
            end
            phg_pkg::S_INIT:
            begin
                flag_next     = '0;
                next_hit_next = 8'd1;
                i_next        = '0;
                state_next    = phg_pkg::S_START;
            end
            phg_pkg::S_START:
            begin
                mark_next   = '0;
                terms_next  = '0;
                tcount_next = '0;
                w_next      = i_reg;
                first_next  = 1'b1;
                state_next  = phg_pkg::S_WREQ;
            end
            phg_pkg::S_WREQ:
            begin
                state_next = phg_pkg::S_WCHK;
            end
            phg_pkg::S_WCHK:
            begin
                if (first_reg)
                begin
                    start_next = rd_reg;
                end
                first_next = 1'b0;
                if (m.brk)
                begin
                    state_next = phg_pkg::S_DONE;
                end
                else if (m.take && cfg_reg.use_sequences && rd_reg.seq_valid && !w_end)
                begin
                    terms_next         = terms_reg | m.term_bit;
                    tcount_next        = newc;
                    mark_next[w_reg]   = 1'b1;
                    stop_next          = stop_now;
                    prev_pos_next      = rd_reg.position;
                    prev_seq_next      = rd_reg.seq_index;
                    run_term_next      = rd_reg.term_number;
                    s_next             = w_reg + IW'(1);
                    state_next         = phg_pkg::S_RREQ;
                end
                else
                begin
                    if (m.take)
                    begin
                        terms_next       = terms_reg | m.term_bit;
                        tcount_next      = newc;
                        mark_next[w_reg] = 1'b1;
                    end
                    if ((m.take && stop_now) || w_end)
                    begin
                        state_next = phg_pkg::S_DONE;
                    end
                    else
                    begin
                        w_next     = w_reg + IW'(1);
                        state_next = phg_pkg::S_WREQ;
                    end
                end
            end
            phg_pkg::S_RREQ:
            begin
                state_next = phg_pkg::S_RCHK;
            end
            phg_pkg::S_RCHK:
            begin
                if (run_ok && (rd_reg.term_number == run_term_reg))
                begin
                    mark_next[s_reg] = 1'b1;
                    prev_pos_next    = rd_reg.position;
                    prev_seq_next    = rd_reg.seq_index;
                end
                if (run_ok && !s_end)
                begin
                    s_next     = s_reg + IW'(1);
                    state_next = phg_pkg::S_RREQ;
                end
                else if (stop_reg || w_end)
                begin
                    state_next = phg_pkg::S_DONE;
                end
                else
                begin
                    w_next     = w_reg + IW'(1);
                    state_next = phg_pkg::S_WREQ;
                end
            end
            phg_pkg::S_DONE:
            begin
                if (tcount_reg == cfg_reg.unique_terms)
                begin
                    fresh_next = (mark_reg & ~flag_reg) != '0;
                    flag_next  = flag_reg | mark_reg;
                    k_next     = '0;
                    state_next = phg_pkg::S_SWEEP;
                end
                else
                begin
                    state_next = phg_pkg::S_NEXT;
                end
            end
            phg_pkg::S_SWEEP:
            begin
                k_next = k_reg + IW'(1);
                if (({1'b0, k_reg} + CW'(1)) >= n_reg)
                begin
                    state_next = phg_pkg::S_NEXT;
                    if (!cfg_reg.collect_all)
                    begin
                        if (next_hit_reg != 8'd255)
                        begin
                            next_hit_next = next_hit_reg + 8'd1;
                        end
                        // repeat a replaceable start while it still claims tokens
                        if (start_reg.replaceable && fresh_reg)
                        begin
                            state_next = phg_pkg::S_START;
                        end
                    end
                end
            end
            phg_pkg::S_NEXT:
            begin
                if (({1'b0, i_reg} + CW'(1)) >= n_reg)
                begin
                    k_next     = '0;
                    state_next = phg_pkg::S_OREQ;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = phg_pkg::S_START;
                end
            end
            phg_pkg::S_OREQ:
            begin
                state_next = phg_pkg::S_OLOAD;
            end
            phg_pkg::S_OLOAD:
            begin
                out_next.token_index = 6'(k_reg);
                out_next.hit_id      = flag_reg[k_reg] ? hit_rd_reg : 8'd0;
                out_next.last_result = ({1'b0, k_reg} + CW'(1)) >= n_reg;
                out_valid_next       = 1'b1;
                state_next           = phg_pkg::S_OHOLD;
            end
            phg_pkg::S_OHOLD:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_reg.last_result)
                    begin
                        cnt_next   = '0;
                        state_next = phg_pkg::S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = phg_pkg::S_OREQ;
                    end
                end
            end
            default:
            begin
                state_next = phg_pkg::S_LOAD;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> bench/hit_grouping_checker.sv
// Checker for the proximity hit grouper: predicts hit numbers per token set and compares.
`timescale 1ns / 1ps
module hit_grouping_checker (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 in_ready,
    input  phg_pkg::in_item_t   in_data,
    input  wire                 out_valid,
    input  wire                 out_ready,
    input  phg_pkg::out_item_t  out_data,
    input  wire                 cfg_valid,
    input  wire                 cfg_ready,
    input  wire [2:0]           cfg_index,
    input  wire [15:0]          cfg_data,
    output int                  errors,
    output int                  waiting
);

    phg_pkg::cfg_t      regs;
    phg_pkg::token_t    tokens [phg_pkg::MAX_TOKENS];
    logic [7:0]         hit_of [phg_pkg::MAX_TOKENS];
    logic [63:0]        picked;
    logic [15:0]        seen_terms;
    int                 loaded;
    int                 hit_no;
    phg_pkg::out_item_t hits_due [$];

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic void follow_run(int start, int n);
        int prev;
        int d;
        prev = start;
        for (int s = start + 1; s < n; s++)
        begin
            d = int'(tokens[s].position) - int'(tokens[prev].position);
            if (d > 1 || d < 0) break;
            if (!tokens[s].seq_valid ||
                int'(tokens[s].seq_index) != int'(tokens[prev].seq_index) + 1) break;
            if (tokens[s].term_number != tokens[start].term_number) continue;
            picked[s] = 1'b1;
            prev = s;
        end
    endfunction

    function automatic void walk_from(int i, int n);
        int   t;
        logic strict;
        picked = '0;
        seen_terms = '0;
        for (int w = i; w < n; w++)
        begin
            t = tokens[w].term_number;
            if (tokens[w].context_id != tokens[i].context_id) break;
            if (int'(tokens[w].position) - int'(tokens[i].position) > int'(regs.window_size))
                break;
            if (regs.use_subcontext && tokens[w].subcontext_id != tokens[i].subcontext_id)
                break;
            if (t < 1 || t > phg_pkg::MAX_TERMS) continue;
            strict = !tokens[w].replaceable && !regs.collect_all;
            if (strict && (hit_of[w] != 0 || seen_terms[t-1])) continue;
            if (regs.directed && t > $countones(seen_terms) + 1) continue;
            seen_terms[t-1] = 1'b1;
            picked[w] = 1'b1;
            if (regs.use_sequences && tokens[w].seq_valid) follow_run(w, n);
            if (strict && $countones(seen_terms) == regs.unique_terms) break;
        end
    endfunction

    function automatic void group_set(int n);
        logic again;
        logic fresh;
        phg_pkg::out_item_t r;
        for (int k = 0; k < phg_pkg::MAX_TOKENS; k++) hit_of[k] = '0;
        hit_no = 1;
        for (int i = 0; i < n; i++)
        begin
            again = 1'b1;
            while (again)
            begin
                again = 1'b0;
                fresh = 1'b0;
                walk_from(i, n);
                if ($countones(seen_terms) != regs.unique_terms) break;
                for (int k = 0; k < n; k++)
                begin
                    if (picked[k])
                    begin
                        if (hit_of[k] == 0) fresh = 1'b1;
                        hit_of[k] = hit_no[7:0];
                    end
                end
                if (!regs.collect_all)
                begin
                    if (hit_no < 255) hit_no++;
                    if (tokens[i].replaceable && fresh) again = 1'b1;
                end
            end
        end
        for (int k = 0; k < n; k++)
        begin
            r.token_index = k[5:0];
            r.hit_id      = hit_of[k];
            r.last_result = (k + 1 == n);
            hits_due.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        phg_pkg::out_item_t want;
        if (!rst_n)
        begin
            regs = '{unique_terms: 5'd1, default: '0};
            loaded = 0;
            hits_due.delete();
            errors = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (hits_due.size() == 0)
                begin
                    report("unexpected result beat, token_index", out_data.token_index, -1);
                end
                else
                begin
                    want = hits_due.pop_front();
                    if (out_data.token_index !== want.token_index)
                        report("token_index", out_data.token_index, want.token_index);
                    if (out_data.hit_id !== want.hit_id)
                        report("hit_id", out_data.hit_id, want.hit_id);
                    if (out_data.last_result !== want.last_result)
                        report("last_result", out_data.last_result, want.last_result);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    phg_pkg::REG_UNIQUE_TERMS:   regs.unique_terms   = cfg_data[4:0];
                    phg_pkg::REG_WINDOW_SIZE:    regs.window_size    = cfg_data;
                    phg_pkg::REG_USE_SUBCONTEXT: regs.use_subcontext = cfg_data[0];
                    phg_pkg::REG_USE_SEQUENCES:  regs.use_sequences  = cfg_data[0];
                    phg_pkg::REG_COLLECT_ALL:    regs.collect_all    = cfg_data[0];
                    phg_pkg::REG_DIRECTED:       regs.directed       = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (loaded < phg_pkg::MAX_TOKENS)
                begin
                    tokens[loaded] = '{in_data.context_id, in_data.subcontext_id,
                                       in_data.position, in_data.term_number,
                                       in_data.seq_index, in_data.seq_valid,
                                       in_data.replaceable};
                    loaded++;
                end
                if (in_data.last_token)
                begin
                    group_set(loaded);
                    loaded = 0;
                end
            end
        end
        waiting = hits_due.size();
    end

endmodule

>>> bench/proximity_hit_grouper_test.sv
// Top of the proximity hit grouper bench: clock, reset, token and register stimulus, verdict.
`timescale 1ns / 1ps
module proximity_hit_grouper_test;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    phg_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    phg_pkg::out_item_t out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    int                 errors;
    int                 waiting;
    int                 rx_hold = 0;
    int                 sent = 0;
    int                 uniq = 1;

    proximity_hit_grouper DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    hit_grouping_checker watch (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .waiting(waiting)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #240_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: long hold-off on request, otherwise short and occasional long stalls
    initial
    begin
        int gap;
        int steady;
        gap = 0;
        steady = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready = 1'b0;
                rx_hold--;
            end
            else if (gap > 0)
            begin
                out_ready = 1'b0;
                gap--;
            end
            else
            begin
                out_ready = 1'b1;
                if (steady > 0)
                    steady--;
                else if ($urandom_range(99) < 3)
                    steady = $urandom_range(200, 30);
                else if ($urandom_range(99) < 25)
                    gap = ($urandom_range(9) == 0) ? $urandom_range(60, 15)
                                                   : $urandom_range(3, 1);
            end
        end
    end

    function automatic phg_pkg::in_item_t tok(int ctx, int sub, int pos, int term, int seq,
                                              bit seqv, bit repl, bit last);
        phg_pkg::in_item_t t;
        t = '{ctx[15:0], sub[15:0], pos[15:0], term[4:0], seq[7:0], seqv, repl, last};
        return t;
    endfunction

    task automatic send(phg_pkg::in_item_t t);
        int gap;
        gap = ($urandom_range(3) == 0) ? (($urandom_range(12) == 0) ? $urandom_range(40, 8)
                                                                     : $urandom_range(3, 1))
                                       : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, int value);
        in_valid  = 1'b0;
        while (waiting != 0) @(negedge clk);
        // let the sequencer settle after the final beat
        repeat (20) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value[15:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == phg_pkg::REG_UNIQUE_TERMS) uniq = value;
    endtask

    task automatic set_all(int u, int win, bit sub, bit seqs, bit coll, bit dir);
        write_reg(phg_pkg::REG_UNIQUE_TERMS, u);
        write_reg(phg_pkg::REG_WINDOW_SIZE, win);
        write_reg(phg_pkg::REG_USE_SUBCONTEXT, sub);
        write_reg(phg_pkg::REG_USE_SEQUENCES, seqs);
        write_reg(phg_pkg::REG_COLLECT_ALL, coll);
        write_reg(phg_pkg::REG_DIRECTED, dir);
    endtask

    // One token set: mostly clustered tokens in a few contexts, some noise when noisy is set
    task automatic send_set(int n, bit noisy);
        int ctx, sub, pos, seq, term, top;
        phg_pkg::in_item_t t;
        ctx = $urandom_range(65535);
        sub = $urandom_range(65535);
        pos = $urandom_range(65535);
        seq = $urandom_range(255);
        top = (uniq >= 1 && uniq <= phg_pkg::MAX_TERMS) ? uniq : phg_pkg::MAX_TERMS;
        for (int k = 0; k < n; k++)
        begin
            if (noisy && $urandom_range(3) == 0)
            begin
                t = phg_pkg::in_item_t'({$urandom, $urandom});
            end
            else
            begin
                if ($urandom_range(9) == 0) ctx = $urandom_range(65535);
                if ($urandom_range(7) == 0) sub = $urandom_range(65535);
                if ($urandom_range(11) == 0) pos = $urandom_range(65535);
                else pos = pos + $urandom_range(2);
                seq = ($urandom_range(3) == 0) ? $urandom_range(255) : seq + 1;
                term = ($urandom_range(19) == 0) ? $urandom_range(31) : $urandom_range(top, 1);
                t = tok(ctx, sub, pos, term, seq, $urandom_range(3) != 0,
                        $urandom_range(3) == 0, 1'b0);
            end
            t.last_token = (k == n - 1);
            send(t);
        end
    endtask

    initial
    begin
        int phase;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset configuration, field extremes, out-of-range terms
        send(tok(0, 0, 0, 1, 0, 0, 0, 1));
        send(tok(16'hFFFF, 16'hFFFF, 16'hFFFF, 16, 255, 1, 1, 0));
        send(tok(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0));
        send(tok(16'hFFFF, 0, 16'hFFFF, 31, 255, 1, 1, 0));
        send(tok(16'hFFFF, 0, 16'hFFFF, 17, 0, 0, 0, 0));
        send(tok(16'hFFFF, 0, 16'hFFFF, 1, 0, 0, 0, 1));
        // sequence runs, directed order, passing over other terms, no seq wrap
        set_all(2, 3, 1, 1, 0, 1);
        send(tok(5, 7, 10, 1, 0, 1, 0, 0));
        send(tok(5, 7, 11, 1, 1, 1, 0, 0));
        send(tok(5, 7, 11, 2, 2, 1, 0, 0));
        send(tok(5, 7, 12, 1, 2, 1, 0, 0));
        send(tok(5, 7, 13, 2, 9, 0, 1, 0));
        send(tok(5, 7, 14, 1, 255, 1, 1, 0));
        send(tok(5, 7, 15, 1, 0, 1, 0, 0));
        send(tok(5, 8, 15, 2, 0, 0, 0, 0));
        send(tok(6, 7, 15, 2, 0, 0, 0, 1));
        // collect-all mode, empty hits with zero terms
        set_all(0, 65535, 0, 0, 1, 0);
        send(tok(1, 1, 100, 2, 0, 0, 0, 0));
        send(tok(1, 1, 0, 3, 0, 0, 1, 0));
        send(tok(1, 1, 65535, 2, 0, 0, 0, 1));
        write_reg(phg_pkg::REG_COLLECT_ALL, 0);
        send(tok(1, 1, 100, 2, 0, 0, 0, 0));
        send(tok(1, 1, 101, 3, 0, 0, 1, 1));

        phase = 0;
        while (sent < 370)
        begin
            case (phase)
                0: set_all(31, 0, 0, 0, 0, 0);
                1: set_all(16, 65535, 1, 1, 0, 1);
                2: set_all(1, 0, 0, 0, 0, 0);
                default:
                    set_all(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(4, 1),
                            ($urandom_range(7) == 0) ? $urandom_range(65535)
                                                     : $urandom_range(20),
                            $urandom_range(1), $urandom_range(1),
                            $urandom_range(5) == 0, $urandom_range(1));
            endcase
            if (phase == 3)
            begin
                // hold results back while further sets are offered
                rx_hold = 3000;
                send_set(66, 1'b0);
            end
            if (phase == 5) send_set(64, 1'b1);
            repeat ($urandom_range(6, 3)) send_set($urandom_range(10, 1), $urandom_range(4) == 0);
            phase++;
        end
        in_valid = 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
